[rtl/core/jet_pkg.sv]
package jet_pkg;

  localparam int CoordW = 32;
  localparam int PixW   = 12;
  localparam int StepW  = 25;
  localparam int LimW   = 29;
  localparam int CountW = 16;
  localparam int IdxW   = 3;

  localparam int QDepth = 4;
  localparam int QAddrW = 2;

  // Register indexes on the configuration port.
  localparam logic [IdxW-1:0] REG_C_REAL    = 3'd0;
  localparam logic [IdxW-1:0] REG_C_IMAG    = 3'd1;
  localparam logic [IdxW-1:0] REG_X_ORIGIN  = 3'd2;
  localparam logic [IdxW-1:0] REG_Y_ORIGIN  = 3'd3;
  localparam logic [IdxW-1:0] REG_X_STEP    = 3'd4;
  localparam logic [IdxW-1:0] REG_Y_STEP    = 3'd5;
  localparam logic [IdxW-1:0] REG_ESC_LIMIT = 3'd6;
  localparam logic [IdxW-1:0] REG_ITER_LIM  = 3'd7;

  localparam logic [CoordW-1:0] RST_C_REAL    = 32'hFF7C_CCCD;
  localparam logic [CoordW-1:0] RST_C_IMAG    = 32'h0085_73EB;
  localparam logic [CoordW-1:0] RST_X_ORIGIN  = 32'hFE00_0000;
  localparam logic [CoordW-1:0] RST_Y_ORIGIN  = 32'hFE66_6666;
  localparam logic [StepW-1:0]  RST_X_STEP    = 25'd65536;
  localparam logic [StepW-1:0]  RST_Y_STEP    = 25'd67109;
  localparam logic [LimW-1:0]   RST_ESC_LIMIT = 29'd67108864;
  localparam logic [CountW-1:0] RST_ITER_LIM  = 16'd1000;

  typedef struct packed {
    logic [CoordW-1:0] c_real;
    logic [CoordW-1:0] c_imag;
    logic [CoordW-1:0] x_origin;
    logic [CoordW-1:0] y_origin;
    logic [StepW-1:0]  x_step;
    logic [StepW-1:0]  y_step;
    logic [LimW-1:0]   escape_limit;
    logic [CountW-1:0] iteration_limit;
  } cfg_t;

  // One mapped pixel on its way from the front end to the iterator.
  typedef struct packed {
    logic [PixW-1:0]   px;
    logic [PixW-1:0]   py;
    logic [CoordW-1:0] re;
    logic [CoordW-1:0] im;
  } pix_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Saturates a wide signed value to 32-bit signed.
  function automatic logic [CoordW-1:0] sat32(input logic signed [64:0] v);
    logic fits;
    fits = (&v[64:31]) | ~(|v[64:31]);
    if (fits) begin
      sat32 = v[31:0];
    end else if (v[64]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7FFF_FFFF;
    end
  endfunction

endpackage

[rtl/core/jet_front.sv]
module jet_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                      in_push,
  input  logic [jet_pkg::PixW-1:0]  in_pixel_x,
  input  logic [jet_pkg::PixW-1:0]  in_pixel_y,
  input  jet_pkg::cfg_t             cfg,
  input  logic                      q_full,
  output logic                      q_push,
  output jet_pkg::pix_item_t        q_item
);
  import jet_pkg::*;

  localparam logic [PixW-1:0] ClampIdx = PixW'(MAX_DIM - 1);

  logic [PixW-1:0]         idx_x, idx_y;
  logic [PixW+StepW-1:0]   prod_x, prod_y;
  logic signed [PixW+StepW+1:0] sum_x, sum_y;

  // An index beyond the image is clamped for the mapping only.
  assign idx_x = (int'(in_pixel_x) >= MAX_DIM) ? ClampIdx : in_pixel_x;
  assign idx_y = (int'(in_pixel_y) >= MAX_DIM) ? ClampIdx : in_pixel_y;

  assign prod_x = (PixW+StepW)'(idx_x) * (PixW+StepW)'(cfg.x_step);
  assign prod_y = (PixW+StepW)'(idx_y) * (PixW+StepW)'(cfg.y_step);

  assign sum_x = $signed({{(PixW+StepW+2-CoordW){cfg.x_origin[CoordW-1]}}, cfg.x_origin})
               + $signed({2'b00, prod_x});
  assign sum_y = $signed({{(PixW+StepW+2-CoordW){cfg.y_origin[CoordW-1]}}, cfg.y_origin})
               + $signed({2'b00, prod_y});

  assign q_push    = in_push && !q_full;
  assign q_item.px = in_pixel_x;
  assign q_item.py = in_pixel_y;
  assign q_item.re = sat32(65'(sum_x));
  assign q_item.im = sat32(65'(sum_y));

endmodule

[rtl/core/jet_queue.sv]
module jet_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  jet_pkg::q_ctrl_t   ctrl,
  input  jet_pkg::pix_item_t wr_item,
  output jet_pkg::q_stat_t   stat,
  output jet_pkg::pix_item_t rd_item
);
  import jet_pkg::*;

  pix_item_t         mem_r [QDepth];
  logic [QAddrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAddrW:0]   cnt_r;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == (QAddrW+1)'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;
  assign rd_item    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.push && stat.full))
    else $error("queue pushed while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.pop && stat.empty))
    else $error("queue popped while empty");
`endif

endmodule

[rtl/core/jet_back.sv]
module jet_back #(
  parameter int FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  jet_pkg::cfg_t                cfg,
  input  jet_pkg::q_stat_t             q_stat,
  input  jet_pkg::pix_item_t           q_item,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [jet_pkg::PixW-1:0]     out_x,
  output logic [jet_pkg::PixW-1:0]     out_y,
  output logic [jet_pkg::CountW-1:0]   out_iterations,
  output logic [jet_pkg::CoordW-1:0]   out_final_real,
  output logic [jet_pkg::CoordW-1:0]   out_final_imag
);
  import jet_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [PixW-1:0]    px_r, py_r;
  logic [CoordW-1:0]  re_r, im_r;
  logic [CountW-1:0]  cnt_r;
  logic [63:0]        rr_r, ii_r;
  logic signed [63:0] ri_r;
  logic               out_valid_r;
  logic [PixW-1:0]    res_x_r, res_y_r;
  logic [CountW-1:0]  res_cnt_r;
  logic [CoordW-1:0]  res_re_r, res_im_r;

  logic [CoordW-1:0]  abs_re, abs_im;
  logic [127:0]       bound_wide;
  logic [63:0]        bound, mag;
  logic               escaped;
  logic signed [64:0] diff, prod_ext, nre, nim;
  logic               res_free;

  assign abs_re = re_r[CoordW-1] ? (~re_r + 32'd1) : re_r;
  assign abs_im = im_r[CoordW-1] ? (~im_r + 32'd1) : im_r;

  // The bailout in the squared-magnitude scale saturates to all ones.
  assign bound_wide = 128'(cfg.escape_limit) << FRAC_BITS;
  assign bound      = (|bound_wide[127:64]) ? '1 : bound_wide[63:0];
  assign mag        = rr_r + ii_r;
  assign escaped    = mag > bound;

  // Arithmetic right shifts give the floor of the scaled products.
  assign diff     = $signed({1'b0, rr_r}) - $signed({1'b0, ii_r});
  assign prod_ext = 65'(ri_r);
  assign nre = (diff >>> FRAC_BITS)
             + $signed({{33{cfg.c_real[CoordW-1]}}, cfg.c_real});
  assign nim = (prod_ext >>> (FRAC_BITS - 1))
             + $signed({{33{cfg.c_imag[CoordW-1]}}, cfg.c_imag});

  assign q_pop    = (state_r == ST_IDLE) && !q_stat.empty;
  assign res_free = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && res_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            px_r    <= q_item.px;
            py_r    <= q_item.py;
            re_r    <= q_item.re;
            im_r    <= q_item.im;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt_r >= cfg.iteration_limit) begin
            state_r <= ST_DONE;
          end else begin
            rr_r    <= 64'(abs_re) * 64'(abs_re);
            ii_r    <= 64'(abs_im) * 64'(abs_im);
            ri_r    <= 64'($signed(re_r)) * 64'($signed(im_r));
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (escaped) begin
            state_r <= ST_DONE;
          end else begin
            re_r    <= sat32(nre);
            im_r    <= sat32(nim);
            cnt_r   <= cnt_r + 1'b1;
            state_r <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (res_free) begin
            res_x_r     <= px_r;
            res_y_r     <= py_r;
            res_cnt_r   <= cnt_r;
            res_re_r    <= re_r;
            res_im_r    <= im_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_x          = res_x_r;
  assign out_y          = res_y_r;
  assign out_iterations = res_cnt_r;
  assign out_final_real = res_re_r;
  assign out_final_imag = res_im_r;

`ifndef NO_ASSERTIONS
  a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (cnt_r < cfg.iteration_limit))
    else $error("iteration started at or beyond the limit");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_pop) |=> (state_r == ST_DONE))
    else $error("result overwritten before its transfer");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_MUL))
    else $error("queue item taken without starting its iteration");
`endif

endmodule

[rtl/core/julia_escape_time_core.sv]
// Julia-set escape-time engine, signed Q8.24 by default.
// Input channel: drive in_pixel_x/in_pixel_y and raise in_push; the pixel is
// transferred on a clock edge where in_full is low. A front end maps it to its
// start value and places it in a four-entry queue.
// Result channel: while out_empty is low the oldest result is on the out_
// ports; raising out_pop transfers it. One result comes out per pixel.
// Configuration: raise cfg_we with cfg_index and cfg_data to write a register;
// write only while the block holds no pixel.
// Iteration: the iterator does each z*z+c step as products (ST_MUL), then
// bailout test and update (ST_UPD). A pixel runs until it reaches the
// iteration limit or escapes; pixels are iterated one at a time.
// Reset empties the queue and the result register and restores the default
// view and constant.
// If the receiver stalls, the finished result is held, the iterator waits
// with the next one, the queue fills and in_full rises.
module julia_escape_time_core #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [jet_pkg::IdxW-1:0]     cfg_index,
  input  logic [jet_pkg::CoordW-1:0]   cfg_data,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [jet_pkg::PixW-1:0]     in_pixel_x,
  input  logic [jet_pkg::PixW-1:0]     in_pixel_y,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [jet_pkg::PixW-1:0]     out_x,
  output logic [jet_pkg::PixW-1:0]     out_y,
  output logic [jet_pkg::CountW-1:0]   out_iterations,
  output logic [jet_pkg::CoordW-1:0]   out_final_real,
  output logic [jet_pkg::CoordW-1:0]   out_final_imag
);
  import jet_pkg::*;

  cfg_t      cfg_r;
  q_ctrl_t   q_ctrl;
  q_stat_t   q_stat;
  pix_item_t wr_item, rd_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real          <= RST_C_REAL;
      cfg_r.c_imag          <= RST_C_IMAG;
      cfg_r.x_origin        <= RST_X_ORIGIN;
      cfg_r.y_origin        <= RST_Y_ORIGIN;
      cfg_r.x_step          <= RST_X_STEP;
      cfg_r.y_step          <= RST_Y_STEP;
      cfg_r.escape_limit    <= RST_ESC_LIMIT;
      cfg_r.iteration_limit <= RST_ITER_LIM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_C_REAL:    cfg_r.c_real          <= cfg_data;
        REG_C_IMAG:    cfg_r.c_imag          <= cfg_data;
        REG_X_ORIGIN:  cfg_r.x_origin        <= cfg_data;
        REG_Y_ORIGIN:  cfg_r.y_origin        <= cfg_data;
        REG_X_STEP:    cfg_r.x_step          <= cfg_data[StepW-1:0];
        REG_Y_STEP:    cfg_r.y_step          <= cfg_data[StepW-1:0];
        REG_ESC_LIMIT: cfg_r.escape_limit    <= cfg_data[LimW-1:0];
        REG_ITER_LIM:  cfg_r.iteration_limit <= cfg_data[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_full = q_stat.full;

  jet_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_push    (in_push),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .cfg        (cfg_r),
    .q_full     (q_stat.full),
    .q_push     (q_ctrl.push),
    .q_item     (wr_item)
  );

  jet_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (q_ctrl),
    .wr_item (wr_item),
    .stat    (q_stat),
    .rd_item (rd_item)
  );

  jet_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_stat         (q_stat),
    .q_item         (rd_item),
    .q_pop          (q_ctrl.pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_iterations (out_iterations),
    .out_final_real (out_final_real),
    .out_final_imag (out_final_imag)
  );

endmodule
